FILE: sv/slm_pkg.sv
package slm_pkg;

  localparam int LIST_DEPTH  = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int FIELD_W     = 32;
  localparam int IDX_W       = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  typedef enum logic [1:0] {
    FUNC_APPEND_A = 2'd0,
    FUNC_APPEND_B = 2'd1,
    FUNC_MERGE    = 2'd2
  } func_t;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  typedef struct packed {
    logic             append;
    logic             clear;
    logic [IDX_W-1:0] rd_idx;
  } lst_ctrl_t;

endpackage

FILE: sv/slm_in_if.sv
interface slm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

FILE: sv/slm_out_if.sv
interface slm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] merged_value;
  logic               last;
  logic               overflow;

  modport source (output valid, output merged_value, output last, output overflow, input ready);
  modport sink   (input valid, input merged_value, input last, input overflow, output ready);
endinterface

FILE: sv/slm_list.sv
module slm_list
  import slm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  lst_ctrl_t              ctrl,
  input  logic [VALUE_WIDTH-1:0] wr_data,
  output logic [VALUE_WIDTH-1:0] rd_data,
  output logic [IDX_W-1:0]       count
);

  logic [VALUE_WIDTH-1:0] mem [LIST_DEPTH];
  logic [IDX_W-1:0]       count_r;
  logic [IDX_W-1:0]       count_nxt;
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic                   full;
  logic                   wr_en;

  assign full  = (count_r == IDX_W'(LIST_DEPTH));
  assign wr_en = ctrl.append && !full;

  always_comb begin
    count_nxt = count_r;
    if (ctrl.clear) begin
      count_nxt = '0;
    end else if (wr_en) begin
      count_nxt = count_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // write at the tail, read the head that the sequencer asks for
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[ADDR_W-1:0]] <= wr_data;
    end
    rd_data_r <= mem[ctrl.rd_idx[ADDR_W-1:0]];
  end

  assign rd_data = rd_data_r;
  assign count   = count_r;

endmodule

FILE: sv/sorted_list_merge.sv
// Two-way merge of two ascending lists of signed values.
// Input channel in_ch carries a func code and a value. Append-to-A and
// append-to-B words store the value at the tail of the chosen list, one word
// per cycle outside a merge; an append to a full list is dropped and sets a
// sticky overflow flag. A merge word emits every stored element of both lists
// on out_ch as one ascending run; the final word has last set and every word
// carries the overflow flag as it stood when the merge was taken. On equal
// heads the element of list B goes first. The merge empties both lists and
// clears the flag; a merge with both lists empty emits nothing. Code 3 is
// ignored. When the merge word is taken, both list read ports fetch their
// heads; the first result is then placed in the output register, and one
// result follows each cycle after that while the receiver does not stall. The
// rate is set by the single head comparator and the registered read port of
// each list memory. in_ch.ready is low for the whole run. When the receiver
// stalls, the output register holds its word and the merge sequencer waits.
// Reset empties both lists, clears the flag and marks the output register
// empty.
module sorted_list_merge
  import slm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  slm_in_if.sink    in_ch,
  slm_out_if.source out_ch
);

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       ia_r, ia_nxt;
  logic [IDX_W-1:0]       ib_r, ib_nxt;
  logic                   ovf_flag_r, ovf_flag_nxt;
  logic                   run_ovf_r, run_ovf_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0]     out_value_r, out_value_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  lst_ctrl_t              ctrl_a, ctrl_b;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [VALUE_WIDTH-1:0] head_a, head_b;
  logic [VALUE_WIDTH-1:0] sel_val;
  logic [IDX_W-1:0]       cnt_a, cnt_b;
  logic [IDX_W-1:0]       ia_adv, ib_adv;
  logic                   in_acc;
  logic                   a_avail, b_avail, a_lt_b, take_a;
  logic                   out_free, step, step_last;

  assign wr_data = VALUE_WIDTH'(in_ch.value);

  slm_list u_list_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl_a),
    .wr_data (wr_data),
    .rd_data (head_a),
    .count   (cnt_a)
  );

  slm_list u_list_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl_b),
    .wr_data (wr_data),
    .rd_data (head_b),
    .count   (cnt_b)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // the shared comparator: A goes only if B is exhausted or A is strictly less than B
  assign a_avail   = (ia_r < cnt_a);
  assign b_avail   = (ib_r < cnt_b);
  assign a_lt_b    = ($signed(head_a) < $signed(head_b));
  assign take_a    = a_avail && (!b_avail || a_lt_b);
  assign sel_val   = take_a ? head_a : head_b;
  assign ia_adv    = ia_r + IDX_W'(take_a);
  assign ib_adv    = ib_r + IDX_W'(!take_a);
  assign step_last = (ia_adv == cnt_a) && (ib_adv == cnt_b);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign step      = (state_r == ST_MERGE) && out_free;

  always_comb begin
    state_nxt     = state_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    ovf_flag_nxt  = ovf_flag_r;
    run_ovf_nxt   = run_ovf_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    ctrl_a.append = 1'b0;
    ctrl_a.clear  = 1'b0;
    ctrl_b.append = 1'b0;
    ctrl_b.clear  = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (func_t'(in_ch.func))
            FUNC_APPEND_A: begin
              ctrl_a.append = 1'b1;
              if (cnt_a == IDX_W'(LIST_DEPTH)) begin
                ovf_flag_nxt = 1'b1;
              end
            end
            FUNC_APPEND_B: begin
              ctrl_b.append = 1'b1;
              if (cnt_b == IDX_W'(LIST_DEPTH)) begin
                ovf_flag_nxt = 1'b1;
              end
            end
            FUNC_MERGE: begin
              run_ovf_nxt  = ovf_flag_r;
              ovf_flag_nxt = 1'b0;
              if ((cnt_a != '0) || (cnt_b != '0)) begin
                state_nxt = ST_MERGE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = FIELD_W'(sel_val);
          out_last_nxt  = step_last;
          out_ovf_nxt   = run_ovf_r;
          ia_nxt        = ia_adv;
          ib_nxt        = ib_adv;
          if (step_last) begin
            ctrl_a.clear = 1'b1;
            ctrl_b.clear = 1'b1;
            ia_nxt       = '0;
            ib_nxt       = '0;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // read ahead so the new head is registered for the next step
    ctrl_a.rd_idx = ia_nxt;
    ctrl_b.rd_idx = ib_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ia_r        <= '0;
      ib_r        <= '0;
      ovf_flag_r  <= 1'b0;
      run_ovf_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ia_r        <= ia_nxt;
      ib_r        <= ib_nxt;
      ovf_flag_r  <= ovf_flag_nxt;
      run_ovf_r   <= run_ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.merged_value = out_value_r;
  assign out_ch.last         = out_last_r;
  assign out_ch.overflow     = out_ovf_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> ((ia_r <= cnt_a) && (ib_r <= cnt_b) && (a_avail || b_avail)))
    else $error("merge index beyond list count");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (step && step_last) |=> ((cnt_a == '0) && (cnt_b == '0) && (state_r == ST_IDLE)))
    else $error("lists not emptied after final word");

  a_merge_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.func == FUNC_MERGE) && ((cnt_a != '0) || (cnt_b != '0)))
      |=> ((state_r == ST_MERGE) && !ovf_flag_r))
    else $error("merge did not start or flag not cleared");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import slm_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 1000;
  localparam int TAIL_CYCLES = 8;
  localparam int RANDOM_ITEMS = 90;
  localparam int MAX_PRINTED = 30;

  typedef struct packed {
    logic [1:0]  code;
    logic [31:0] value;
    logic        drain;
  } stim_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
    logic               ovf;
  } run_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  slm_in_if  in_ch ();
  slm_out_if out_ch ();

  sorted_list_merge uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  stim_t     pending_q[$];
  run_word_t run_q[$];

  // shadow of the two lists and the sticky flag
  logic signed [31:0] list_a[LIST_DEPTH];
  logic signed [31:0] list_b[LIST_DEPTH];
  int   cnt_a = 0;
  int   cnt_b = 0;
  logic ovf_flag = 1'b0;

  int errors = 0;
  int in_taken = 0;
  int out_taken = 0;
  int n_items = 0;
  int n_counted = 0;
  int quiet = 0;

  task automatic report_mismatch(string msg);
    if (errors < MAX_PRINTED)
      $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void merge_predict(logic [1:0] code, logic signed [31:0] v);
    int ia;
    int ib;
    int total;
    run_word_t w;
    ia = 0;
    ib = 0;
    if (code == FUNC_APPEND_A) begin
      if (cnt_a >= LIST_DEPTH) ovf_flag = 1'b1;
      else begin
        list_a[cnt_a] = v;
        cnt_a++;
      end
    end else if (code == FUNC_APPEND_B) begin
      if (cnt_b >= LIST_DEPTH) ovf_flag = 1'b1;
      else begin
        list_b[cnt_b] = v;
        cnt_b++;
      end
    end else if (code == FUNC_MERGE) begin
      total = cnt_a + cnt_b;
      for (int n = 0; n < total; n++) begin
        // A wins only when strictly smaller, so B goes first on a tie
        if (ia < cnt_a && (ib >= cnt_b || list_a[ia] < list_b[ib])) begin
          w.value = list_a[ia];
          ia++;
        end else begin
          w.value = list_b[ib];
          ib++;
        end
        w.last = (n + 1 == total);
        w.ovf  = ovf_flag;
        run_q.push_back(w);
      end
      cnt_a = 0;
      cnt_b = 0;
      ovf_flag = 1'b0;
    end
  endfunction

  task automatic push_item(logic [1:0] code, logic [31:0] value, logic drain = 1'b0);
    stim_t s;
    s.code = code;
    s.value = value;
    s.drain = drain;
    pending_q.push_back(s);
    n_items++;
    if (code != FUNC_UNUSED) n_counted++;
  endtask

  // append two lists in random interleaving, then merge them
  task automatic add_run(int na, int nb, bit drain);
    int qa[$];
    int qb[$];
    bit narrow;
    bit first;
    bit pick_a;
    narrow = $urandom_range(0, 1);
    first = 1'b1;
    for (int i = 0; i < na; i++)
      qa.push_back(narrow ? $urandom_range(0, 20) - 10 : int'($urandom));
    for (int i = 0; i < nb; i++)
      qb.push_back(narrow ? $urandom_range(0, 20) - 10 : int'($urandom));
    // leave the odd run unsorted
    if ($urandom_range(0, 7) != 0) begin
      qa.sort();
      qb.sort();
    end
    while (qa.size() != 0 || qb.size() != 0) begin
      if ($urandom_range(0, 9) == 0)
        push_item(FUNC_UNUSED, $urandom);
      pick_a = (qb.size() == 0) || (qa.size() != 0 && $urandom_range(0, 1));
      if (pick_a) push_item(FUNC_APPEND_A, qa.pop_front(), drain && first);
      else push_item(FUNC_APPEND_B, qb.pop_front(), drain && first);
      first = 1'b0;
    end
    push_item(FUNC_MERGE, $urandom, drain && first);
  endtask

  // driver
  always @(posedge clk) begin
    stim_t s;
    logic  idle;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        merge_predict(in_ch.func, in_ch.value);
        in_taken++;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        idle = !(in_taken >= 40 && in_taken < 80) && ($urandom_range(0, 99) < 25);
        if (pending_q.size() != 0 && !idle && !(pending_q[0].drain && run_q.size() != 0)) begin
          s = pending_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func  <= s.code;
          in_ch.value <= s.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    run_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_taken++;
        if (run_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %0d", out_ch.merged_value));
        end else begin
          want = run_q.pop_front();
          if (out_ch.merged_value !== want.value)
            report_mismatch($sformatf("merged_value %0d, want %0d",
                                      out_ch.merged_value, want.value));
          if (out_ch.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", out_ch.last, want.last));
          if (out_ch.overflow !== want.ovf)
            report_mismatch($sformatf("overflow %b, want %b", out_ch.overflow, want.ovf));
        end
      end
      out_ch.ready <= (out_taken >= 60 && out_taken < 120) || ($urandom_range(0, 99) >= 25);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int seq;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_APPEND_A;
    in_ch.value = '0;
    out_ch.ready = 1'b0;

    // empty merge, unused code, extremes, unsorted A, tie between heads
    push_item(FUNC_MERGE, 32'h0);
    push_item(FUNC_UNUSED, 32'hFFFF_FFFF);
    push_item(FUNC_APPEND_A, 32'h8000_0000);
    push_item(FUNC_APPEND_A, 32'd5);
    push_item(FUNC_APPEND_B, 32'd5);
    push_item(FUNC_APPEND_B, 32'h7FFF_FFFF);
    push_item(FUNC_APPEND_A, 32'hFFFF_FFFF);
    push_item(FUNC_UNUSED, 32'h0);
    push_item(FUNC_MERGE, 32'hFFFF_FFFF);
    // hold the next run until the previous one has drained
    push_item(FUNC_APPEND_A, 32'd7, 1'b1);
    push_item(FUNC_APPEND_B, 32'd7);
    push_item(FUNC_MERGE, 32'h5555_5555);
    push_item(FUNC_APPEND_A, 32'h7FFF_FFFF);
    push_item(FUNC_MERGE, 32'hAAAA_AAAA);
    push_item(FUNC_APPEND_B, 32'h8000_0000);
    push_item(FUNC_APPEND_B, -32'sd3);
    push_item(FUNC_MERGE, 32'h0);

    n_counted = 0;
    seq = 0;
    while (n_counted < RANDOM_ITEMS) begin
      if (seq == 2)
        add_run(LIST_DEPTH + 1, LIST_DEPTH + 1, 1'b0);
      else if ($urandom_range(0, 11) == 0)
        add_run($urandom_range(0, LIST_DEPTH + 2), $urandom_range(0, 6), seq % 3 == 1);
      else
        add_run($urandom_range(0, 6), $urandom_range(0, 6), seq % 3 == 1);
      seq++;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (in_taken != n_items || run_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (run_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", run_q.size()));

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sorted_list_merge.f
sv/slm_pkg.sv
sv/slm_in_if.sv
sv/slm_out_if.sv
sv/slm_list.sv
sv/sorted_list_merge.sv
sim/tb.sv
